FILE: design/uirp_pkg.sv
// ----------------------------------------------------------------------------
// uirp_pkg
// Beat types and constants for the user identity request sub-item parser.
// ----------------------------------------------------------------------------
package uirp_pkg;

  localparam int unsigned AvailW = 17;
  localparam int unsigned LenW   = 16;

  localparam logic [AvailW-1:0] AvailMax = 17'd65539;
  localparam logic [AvailW-1:0] MinAvail = 17'd10;
  localparam logic [LenW-1:0]   MinItem  = 16'd6;
  localparam logic [AvailW-1:0] HdrLen   = 17'd4;

  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindPrim = 2'd1;
  localparam logic [1:0] KindSec  = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StIllegal = 2'd1;
  localparam logic [1:0] StCorrupt = 2'd2;

  localparam logic [2:0] IdUnknown = 3'd0;
  localparam logic [2:0] IdUserPw  = 3'd2;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              first_byte;
    logic [AvailW-1:0] avail_length;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]        payload_byte;
    logic [1:0]        payload_kind;
    logic              done_res;
    logic [1:0]        status;
    logic [2:0]        identity_kind;
    logic [7:0]        positive_response;
    logic [LenW-1:0]   primary_length;
    logic [LenW-1:0]   secondary_length;
    logic [AvailW-1:0] bytes_consumed;
  } out_beat_t;

endpackage

FILE: design/user_identity_request_item_parser.sv
// ----------------------------------------------------------------------------
// user_identity_request_item_parser
// Byte-wide parser for a user identity request sub-item with field forwarding.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | uirp_pkg::in_beat_t
//  out_    | output    | out_valid/out_stall| uirp_pkg::out_beat_t
//
// one beat per cycle; each byte is parsed in its accept cycle and any result
// appears on the output register the cycle after
// the output register is the only stage: input stalls only while a result is
// held there under out_stall
// reset returns the parser to idle; bytes are ignored until a first byte
// ----------------------------------------------------------------------------
module user_identity_request_item_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  uirp_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output uirp_pkg::out_beat_t  out_data
);
  import uirp_pkg::*;

  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhHead = 3'd1;
  localparam logic [2:0] PhPrim = 3'd2;
  localparam logic [2:0] PhSlen = 3'd3;
  localparam logic [2:0] PhSec  = 3'd4;
  localparam logic [2:0] PhDone = 3'd5;

  localparam logic [AvailW-1:0] PosLenHi  = 17'd2;
  localparam logic [AvailW-1:0] PosLenLo  = 17'd3;
  localparam logic [AvailW-1:0] PosIdent  = 17'd4;
  localparam logic [AvailW-1:0] PosFlag   = 17'd5;
  localparam logic [AvailW-1:0] PosPrimHi = 17'd6;
  localparam logic [AvailW-1:0] PosPrimLo = 17'd7;

  logic [2:0]        phase_r, phase_nxt;
  logic [AvailW-1:0] pos_r, pos_nxt;
  logic [LenW-1:0]   item_r, item_nxt;
  logic [AvailW-1:0] avail_r, avail_nxt;
  logic [LenW-1:0]   prim_r, prim_nxt;
  logic [LenW-1:0]   sec_r, sec_nxt;
  logic [2:0]        ident_r, ident_nxt;
  logic [7:0]        flag_r, flag_nxt;

  logic              out_valid_r;
  out_beat_t         out_data_r;
  logic              res_vld;
  out_beat_t         res;

  logic              in_accept;
  logic              out_load;
  logic [AvailW-1:0] avail_sat;
  logic [AvailW-1:0] prim_ext;
  logic [AvailW-1:0] prim_end;
  logic [AvailW-1:0] consumed_prim;
  logic [AvailW-1:0] consumed_all;
  logic [7:0]        b;

  assign out_load  = !out_valid_r || !out_stall;
  assign in_stall  = !out_load;
  assign in_accept = in_valid && out_load;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b             = in_data.data_byte;
  assign avail_sat     = (in_data.avail_length > AvailMax) ? AvailMax : in_data.avail_length;
  assign prim_ext      = {1'b0, prim_r};
  assign prim_end      = 17'd8 + prim_ext;
  assign consumed_prim = 17'd10 + prim_ext;

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    item_nxt     = item_r;
    avail_nxt    = avail_r;
    prim_nxt     = prim_r;
    sec_nxt      = sec_r;
    ident_nxt    = ident_r;
    flag_nxt     = flag_r;
    res_vld      = 1'b0;
    res          = '0;
    consumed_all = 17'd10 + prim_ext + {1'b0, sec_r};
    if (in_accept) begin
      if (in_data.first_byte) begin
        item_nxt  = '0;
        prim_nxt  = '0;
        sec_nxt   = '0;
        ident_nxt = IdUnknown;
        flag_nxt  = '0;
        avail_nxt = avail_sat;
        pos_nxt   = 17'd1;
        if (avail_sat < MinAvail) begin
          phase_nxt    = PhDone;
          res_vld      = 1'b1;
          res.done_res = 1'b1;
          res.status   = StIllegal;
        end else begin
          phase_nxt = PhHead;
        end
      end else begin
        case (phase_r)
          PhHead: begin
            pos_nxt = pos_r + 17'd1;
            case (pos_r)
              PosLenHi: item_nxt = {b, 8'd0};
              PosLenLo: begin
                item_nxt = {item_r[15:8], b};
                if ((avail_r - HdrLen) < {1'b0, item_r[15:8], b}) begin
                  phase_nxt    = PhDone;
                  res_vld      = 1'b1;
                  res.done_res = 1'b1;
                  res.status   = StIllegal;
                end else if ({item_r[15:8], b} < MinItem) begin
                  phase_nxt    = PhDone;
                  res_vld      = 1'b1;
                  res.done_res = 1'b1;
                  res.status   = StCorrupt;
                end
              end
              PosIdent: ident_nxt = (b inside {[8'd1:8'd4]}) ? b[2:0] : IdUnknown;
              PosFlag: flag_nxt = b;
              PosPrimHi: prim_nxt = {b, 8'd0};
              PosPrimLo: begin
                prim_nxt = {prim_r[15:8], b};
                if ((item_r - MinItem) < {prim_r[15:8], b}) begin
                  phase_nxt    = PhDone;
                  res_vld      = 1'b1;
                  res.done_res = 1'b1;
                  res.status   = StIllegal;
                end else if ({prim_r[15:8], b} != 16'd0) begin
                  phase_nxt = PhPrim;
                end else begin
                  phase_nxt = PhSlen;
                end
              end
              default: ;
            endcase
          end
          PhPrim: begin
            pos_nxt = pos_r + 17'd1;
            if ((pos_r + 17'd1) >= prim_end) begin
              phase_nxt = PhSlen;
            end
            res_vld          = 1'b1;
            res.payload_byte = b;
            res.payload_kind = KindPrim;
          end
          PhSlen: begin
            pos_nxt = pos_r + 17'd1;
            if (pos_r == prim_end) begin
              sec_nxt = {b, 8'd0};
            end else begin
              sec_nxt = {sec_r[15:8], b};
              if ((item_r - MinItem - prim_r) < {sec_r[15:8], b}) begin
                phase_nxt          = PhDone;
                res_vld            = 1'b1;
                res.done_res       = 1'b1;
                res.status         = StIllegal;
                res.bytes_consumed = consumed_prim;
              end else if ((ident_r == IdUserPw) && ({sec_r[15:8], b} != 16'd0)) begin
                phase_nxt = PhSec;
              end else begin
                phase_nxt          = PhDone;
                res_vld            = 1'b1;
                res.done_res       = 1'b1;
                res.status         = StOk;
                res.bytes_consumed = consumed_prim;
              end
            end
          end
          PhSec: begin
            pos_nxt          = pos_r + 17'd1;
            res_vld          = 1'b1;
            res.payload_byte = b;
            res.payload_kind = KindSec;
            if ((pos_r + 17'd1) >= consumed_all) begin
              phase_nxt          = PhDone;
              res.done_res       = 1'b1;
              res.status         = StOk;
              res.bytes_consumed = consumed_all;
            end
          end
          default: ;
        endcase
      end
    end
    res.identity_kind     = ident_nxt;
    res.positive_response = flag_nxt;
    res.primary_length    = prim_nxt;
    res.secondary_length  = sec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PhIdle;
      pos_r       <= '0;
      item_r      <= '0;
      avail_r     <= '0;
      prim_r      <= '0;
      sec_r       <= '0;
      ident_r     <= IdUnknown;
      flag_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      item_r  <= item_nxt;
      avail_r <= avail_nxt;
      prim_r  <= prim_nxt;
      sec_r   <= sec_nxt;
      ident_r <= ident_nxt;
      flag_r  <= flag_nxt;
      if (out_load) begin
        out_valid_r <= res_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

endmodule

FILE: tb/uirp_parse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uirp_parse_checker
// Follows both channels of the user identity request sub-item parser. Each
// accepted input beat is run through a local copy of the parse, and the
// result beats it should cause are queued. Each accepted output beat is
// checked field by field against the oldest queued beat.
// ----------------------------------------------------------------------------
module uirp_parse_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  uirp_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  uirp_pkg::out_beat_t out_data,
  output int                  fail_count,
  output int                  awaited_count
);
  import uirp_pkg::*;

  typedef enum logic [2:0] {
    PhIdle, PhHead, PhPrim, PhSlen, PhSec, PhDone
  } parse_ph_t;

  parse_ph_t         ph;
  logic [AvailW-1:0] pos;
  logic [LenW-1:0]   item_len;
  logic [AvailW-1:0] avail_cnt;
  logic [LenW-1:0]   prim_len;
  logic [LenW-1:0]   sec_len;
  logic [2:0]        id_code;
  logic [7:0]        resp_flag;

  out_beat_t awaited_beats[$];

  function automatic void clear_parse();
    ph        = PhIdle;
    pos       = '0;
    item_len  = '0;
    avail_cnt = '0;
    prim_len  = '0;
    sec_len   = '0;
    id_code   = IdUnknown;
    resp_flag = '0;
  endfunction

  function automatic out_beat_t result_beat(logic [7:0] pb, logic [1:0] kind, logic done,
                                            logic [1:0] st, logic [AvailW-1:0] consumed);
    out_beat_t r;
    r.payload_byte      = pb;
    r.payload_kind      = kind;
    r.done_res          = done;
    r.status            = st;
    r.identity_kind     = id_code;
    r.positive_response = resp_flag;
    r.primary_length    = prim_len;
    r.secondary_length  = sec_len;
    r.bytes_consumed    = consumed;
    return r;
  endfunction

  function automatic out_beat_t end_parse(logic [7:0] pb, logic [1:0] kind, logic [1:0] st,
                                          logic [AvailW-1:0] consumed);
    ph = PhDone;
    return result_beat(pb, kind, 1'b1, st, consumed);
  endfunction

  // one byte through the parse; returns 1 when a result beat is due
  function automatic bit parse_byte(input in_beat_t b, output out_beat_t r);
    logic [AvailW-1:0] p;
    logic [AvailW-1:0] prim_x;
    logic [AvailW-1:0] span;
    bit                got;
    got = 1'b0;
    r   = '0;
    if (b.first_byte) begin
      clear_parse();
      avail_cnt = (b.avail_length > AvailMax) ? AvailMax : b.avail_length;
      pos       = AvailW'(1);
      if (avail_cnt < MinAvail) begin
        r   = end_parse(8'd0, KindNone, StIllegal, '0);
        got = 1'b1;
      end else begin
        ph = PhHead;
      end
      return got;
    end
    p      = pos;
    prim_x = {1'b0, prim_len};
    case (ph)
      PhHead: begin
        pos = p + AvailW'(1);
        case (p)
          2: item_len = {b.data_byte, 8'h00};
          3: begin
            item_len = {item_len[15:8], b.data_byte};
            if (avail_cnt - HdrLen < {1'b0, item_len}) begin
              r   = end_parse(8'd0, KindNone, StIllegal, '0);
              got = 1'b1;
            end else if (item_len < MinItem) begin
              r   = end_parse(8'd0, KindNone, StCorrupt, '0);
              got = 1'b1;
            end
          end
          4: id_code = (b.data_byte >= 8'd1 && b.data_byte <= 8'd4) ? b.data_byte[2:0]
                                                                    : IdUnknown;
          5: resp_flag = b.data_byte;
          6: prim_len = {b.data_byte, 8'h00};
          7: begin
            prim_len = {prim_len[15:8], b.data_byte};
            if (item_len - MinItem < prim_len) begin
              r   = end_parse(8'd0, KindNone, StIllegal, '0);
              got = 1'b1;
            end else begin
              ph = (prim_len != '0) ? PhPrim : PhSlen;
            end
          end
          default: ;
        endcase
      end
      PhPrim: begin
        pos = p + AvailW'(1);
        if (pos >= prim_x + AvailW'(8)) ph = PhSlen;
        r   = result_beat(b.data_byte, KindPrim, 1'b0, StOk, '0);
        got = 1'b1;
      end
      PhSlen: begin
        pos = p + AvailW'(1);
        if (p == prim_x + AvailW'(8)) begin
          sec_len = {b.data_byte, 8'h00};
        end else begin
          sec_len = {sec_len[15:8], b.data_byte};
          if (item_len - MinItem - prim_len < sec_len) begin
            r   = end_parse(8'd0, KindNone, StIllegal, prim_x + AvailW'(10));
            got = 1'b1;
          end else if (id_code == IdUserPw && sec_len != '0) begin
            ph = PhSec;
          end else begin
            r   = end_parse(8'd0, KindNone, StOk, prim_x + AvailW'(10));
            got = 1'b1;
          end
        end
      end
      PhSec: begin
        pos  = p + AvailW'(1);
        span = prim_x + {1'b0, sec_len} + AvailW'(10);
        if (pos >= span)
          r = end_parse(b.data_byte, KindSec, StOk, span);
        else
          r = result_beat(b.data_byte, KindSec, 1'b0, StOk, '0);
        got = 1'b1;
      end
      default: ;
    endcase
    return got;
  endfunction

  task automatic report(string what, logic [AvailW-1:0] got, logic [AvailW-1:0] want);
    fail_count++;
    $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    out_beat_t due;
    if (!rst_n) begin
      clear_parse();
      awaited_beats.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_beats.size() == 0) begin
          report("unexpected beat", out_data.bytes_consumed, '0);
        end else begin
          want = awaited_beats.pop_front();
          if (out_data.payload_byte !== want.payload_byte)
            report("payload_byte", AvailW'(out_data.payload_byte),
                   AvailW'(want.payload_byte));
          if (out_data.payload_kind !== want.payload_kind)
            report("payload_kind", AvailW'(out_data.payload_kind),
                   AvailW'(want.payload_kind));
          if (out_data.done_res !== want.done_res)
            report("done_res", AvailW'(out_data.done_res), AvailW'(want.done_res));
          if (out_data.status !== want.status)
            report("status", AvailW'(out_data.status), AvailW'(want.status));
          if (out_data.identity_kind !== want.identity_kind)
            report("identity_kind", AvailW'(out_data.identity_kind),
                   AvailW'(want.identity_kind));
          if (out_data.positive_response !== want.positive_response)
            report("positive_response", AvailW'(out_data.positive_response),
                   AvailW'(want.positive_response));
          if (out_data.primary_length !== want.primary_length)
            report("primary_length", AvailW'(out_data.primary_length),
                   AvailW'(want.primary_length));
          if (out_data.secondary_length !== want.secondary_length)
            report("secondary_length", AvailW'(out_data.secondary_length),
                   AvailW'(want.secondary_length));
          if (out_data.bytes_consumed !== want.bytes_consumed)
            report("bytes_consumed", out_data.bytes_consumed, want.bytes_consumed);
        end
      end
      if (in_valid && !in_stall) begin
        if (parse_byte(in_data, due)) awaited_beats.push_back(due);
      end
    end
    awaited_count <= awaited_beats.size();
  end

endmodule

FILE: tb/user_identity_request_item_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// user_identity_request_item_parser_tb
// Feeds the sub-item parser byte by byte: a short directed run through the
// error paths and stray bytes, then randomised sub-items, mostly well formed,
// with faults, cut-short items and trailing noise mixed in. Both sides idle
// at random. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module user_identity_request_item_parser_tb;
  import uirp_pkg::*;

  localparam int StallMax   = 6;
  localparam int QuietLimit = 500;
  localparam int ByteTarget = 950;
  localparam int CutLimit   = 40;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  int fail_count;
  int awaited_count;
  int bytes_sent;
  int quiet_cycles;
  int out_hold;
  bit idle_on = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  user_identity_request_item_parser dut (.*);

  uirp_parse_checker checker_i (.*);

  // receiver stall: drawn afresh after every accepted result beat
  always @(posedge clk) begin
    if (!rst_n) begin
      out_hold = 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      out_hold = idle_on ? $urandom_range(0, StallMax) : 0;
      out_stall <= (out_hold != 0);
    end else if (out_hold != 0) begin
      out_hold = out_hold - 1;
      out_stall <= (out_hold != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(logic [7:0] data, logic first, logic [AvailW-1:0] avail);
    int gap;
    gap = idle_on ? $urandom_range(0, StallMax) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: data, first_byte: first, avail_length: avail};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_stray();
    send_beat(8'($urandom_range(0, 255)), 1'b0, AvailW'($urandom_range(0, AvailMax)));
  endtask

  // sends the first nbytes of a sub-item, padded with noise past its end
  task automatic send_item(int avail, int item_len, int id, int flag, int plen, int slen,
                           int nbytes);
    logic [7:0]      stream[$];
    logic [LenW-1:0] il;
    logic [LenW-1:0] pl;
    logic [LenW-1:0] sl;
    il = LenW'(item_len);
    pl = LenW'(plen);
    sl = LenW'(slen);
    stream = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), il[15:8], il[7:0],
              8'(id), 8'(flag), pl[15:8], pl[7:0]};
    for (int i = 0; i < pl && stream.size() < nbytes; i++)
      stream.push_back(8'($urandom_range(0, 255)));
    stream.push_back(sl[15:8]);
    stream.push_back(sl[7:0]);
    for (int i = 0; i < sl && stream.size() < nbytes; i++)
      stream.push_back(8'($urandom_range(0, 255)));
    while (stream.size() < nbytes) stream.push_back(8'($urandom_range(0, 255)));
    for (int k = 0; k < nbytes; k++)
      send_beat(stream[k], k == 0,
                (k == 0) ? AvailW'(avail) : AvailW'($urandom_range(0, AvailMax)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
  endtask

  initial begin
    int items;
    int avail;
    int item_len;
    int id;
    int plen;
    int slen;
    int full;
    int nbytes;
    items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_stray();
    send_item(9, 7, 1, 0, 0, 0, 1);                        // buffer too short
    send_stray();
    send_item(10, 7, 1, 0, 0, 0, 4);                       // item larger than buffer
    send_item(AvailMax, 5, 1, 0, 0, 0, 4);                 // item too short
    send_item(AvailMax, 65535, 0, 255, 65535, 0, 8);       // primary too long
    send_item(10, 6, 2, 1, 0, 1, 10);                      // secondary too long
    drain();

    while (bytes_sent < ByteTarget) begin
      items++;
      if (items % 8 == 0) idle_on = ($urandom_range(0, 3) != 0);
      plen     = $urandom_range(0, 12);
      slen     = $urandom_range(0, 12);
      id       = ($urandom_range(0, 2) == 0) ? 2 : $urandom_range(1, 4);
      if ($urandom_range(0, 7) == 0) id = $urandom_range(0, 255);
      item_len = 6 + plen + slen + $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0) item_len = 65535;
      avail    = item_len + 4 + $urandom_range(0, 8);
      if (avail > AvailMax) avail = AvailMax;
      case ($urandom_range(0, 9))
        0: avail = $urandom_range(0, 11);
        1: item_len = $urandom_range(0, 7);
        2: plen = item_len - 5 + $urandom_range(0, 3);
        3: slen = item_len - 5 - plen + $urandom_range(0, 2);
        4: avail = item_len + 3 - $urandom_range(0, 2);
        default: ;
      endcase
      full   = 10 + plen + slen;
      nbytes = full + $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(1, full);
      if (nbytes > CutLimit) nbytes = CutLimit;
      send_item(avail, item_len, id, $urandom_range(0, 255), plen, slen, nbytes);
      if ($urandom_range(0, 24) == 0) drain();
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && awaited_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
